/* hdl/fla_pkg.sv */
// fla_pkg: shared types and constants for the free-list heap allocator
// used by fla_core, free_list_heap_allocator and fla_checker; no dependencies

package fla_pkg;

   localparam int OFF_W  = 16;
   localparam int SIZE_W = 17;
   localparam int REQ_W  = 18;

   typedef struct packed {
      logic              has_pointer;
      logic [OFF_W-1:0]  payload_offset;
      logic [SIZE_W-1:0] old_size;
      logic [SIZE_W-1:0] new_size;
   } req_type;

   typedef struct packed {
      logic              result_present;
      logic [OFF_W-1:0]  result_offset;
      logic              out_of_memory;
      logic              copy_needed;
      logic [OFF_W-1:0]  copy_source;
      logic [SIZE_W-1:0] copy_length;
   } rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

endpackage

/* hdl/fla_ram.sv */
// fla_ram: generic single write port, single read port ram with registered read
// no dependencies

module fla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/fla_alu.sv */
// fla_alu: shared adder with sign test, res = a + b + c - d
// no dependencies

module fla_alu #(
   parameter int W = 20
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [W-1:0] c,
   input  logic [W-1:0] d,
   output logic [W-1:0] res,
   output logic         nonneg
);

   assign res    = a + b + c - d;
   assign nonneg = ~res[W-1];

endmodule

/* hdl/fla_core.sv */
// fla_core: sequencer for the allocator, slot memory and shared adder
// depends on fla_pkg, fla_ram, fla_alu

module fla_core #(
   parameter int HEAP_BYTES   = 65536,
   parameter int HEADER_BYTES = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  fla_pkg::req_type    req,
   input  logic                out_ready,
   output fla_pkg::status_type status,
   output fla_pkg::rsp_type    rsp
);

   localparam int HDR   = ((HEADER_BYTES + 7) / 8) * 8;
   localparam int SLOTS = (HEAP_BYTES + 7) / 8;
   localparam int IW    = $clog2(SLOTS);
   localparam int SW    = $clog2(HEAP_BYTES);
   localparam int HW0   = $clog2(HEAP_BYTES + 1);
   localparam int AW    = ((HW0 > fla_pkg::REQ_W) ? HW0 : fla_pkg::REQ_W) + 2;

   localparam logic [AW-1:0] NEG_HDR  = AW'(0) - AW'(HDR);
   localparam logic [AW-1:0] NEG_HDR8 = AW'(0) - AW'(HDR + 8);

   localparam logic [5:0] S_CLEAR     = 6'd0;
   localparam logic [5:0] S_IDLE      = 6'd1;
   localparam logic [5:0] S_DECODE    = 6'd2;
   localparam logic [5:0] S_CHK       = 6'd3;
   localparam logic [5:0] S_GROWCHK   = 6'd4;
   localparam logic [5:0] S_GROW_ABS  = 6'd5;
   localparam logic [5:0] S_GROW_SPL  = 6'd6;
   localparam logic [5:0] S_NEW_GOT   = 6'd7;
   localparam logic [5:0] S_NEW_SPL   = 6'd8;
   localparam logic [5:0] S_MOVE_GOT  = 6'd9;
   localparam logic [5:0] S_MOVE_LEN  = 6'd10;
   localparam logic [5:0] S_MOVE_SPL  = 6'd11;
   localparam logic [5:0] S_DONE      = 6'd12;
   localparam logic [5:0] S_FREE0     = 6'd13;
   localparam logic [5:0] S_FREE1     = 6'd14;
   localparam logic [5:0] S_FREE2     = 6'd15;
   localparam logic [5:0] S_FREE3     = 6'd16;
   localparam logic [5:0] S_FREE4     = 6'd17;
   localparam logic [5:0] S_FREE_ABS  = 6'd18;
   localparam logic [5:0] S_FREE_PABS = 6'd19;
   localparam logic [5:0] S_FREE_PINS = 6'd20;
   localparam logic [5:0] S_UNL0      = 6'd21;
   localparam logic [5:0] S_UNL1      = 6'd22;
   localparam logic [5:0] S_UNL2      = 6'd23;
   localparam logic [5:0] S_UNL3      = 6'd24;
   localparam logic [5:0] S_INS0      = 6'd25;
   localparam logic [5:0] S_INS1      = 6'd26;
   localparam logic [5:0] S_INS2      = 6'd27;
   localparam logic [5:0] S_ABS0      = 6'd28;
   localparam logic [5:0] S_ABS1      = 6'd29;
   localparam logic [5:0] S_ABS2      = 6'd30;
   localparam logic [5:0] S_ABS3      = 6'd31;
   localparam logic [5:0] S_ABS4      = 6'd32;
   localparam logic [5:0] S_SPL0      = 6'd33;
   localparam logic [5:0] S_SPL1      = 6'd34;
   localparam logic [5:0] S_SPL2      = 6'd35;
   localparam logic [5:0] S_SPL3      = 6'd36;
   localparam logic [5:0] S_SPL4      = 6'd37;
   localparam logic [5:0] S_SPL5      = 6'd38;
   localparam logic [5:0] S_SRC0      = 6'd39;
   localparam logic [5:0] S_SRC1      = 6'd40;

   typedef struct packed {
      logic [SW-1:0] size;
      logic          free;
      logic          live;
      logic          hp;
      logic          hn;
      logic          hpf;
      logic          hnf;
      logic [IW-1:0] prev;
      logic [IW-1:0] next;
      logic [IW-1:0] pf;
      logic [IW-1:0] nf;
   } slot_type;

   logic [5:0]                  state_ff, state_in, ret_ff, ret_in;
   logic [IW-1:0]               clr_ff, clr_in;
   logic                        hd_ok_ff, hd_ok_in;
   logic [IW-1:0]               hd_ff, hd_in;
   logic [IW-1:0]               x_ff, x_in, i_ff, i_in, cur_ff, cur_in;
   logic [IW-1:0]               nx_ff, nx_in, rr_ff, rr_in, fprev_ff, fprev_in;
   logic                        fhp_ff, fhp_in, found_ff, found_in;
   logic [SW-1:0]               bsize_ff, bsize_in;
   logic [fla_pkg::REQ_W-1:0]   req_ff, req_in;
   logic [fla_pkg::SIZE_W-1:0]  m1_ff, m1_in;
   fla_pkg::req_type            in_ff, in_in;
   fla_pkg::rsp_type            res_ff, res_in;
   slot_type                    t_ff, t_in, n_ff, n_in;

   slot_type                    rd, wr_rec, init_rec;
   logic                        wr_en;
   logic [IW-1:0]               wr_addr, rd_addr;
   logic [$bits(slot_type)-1:0] rd_data;
   logic [AW-1:0]               alu_a, alu_b, alu_c, alu_d, alu_res;
   logic                        alu_nonneg;
   logic [fla_pkg::REQ_W-1:0]   round_sum;

   fla_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fla_alu #(
      .W (AW)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .c      (alu_c),
      .d      (alu_d),
      .res    (alu_res),
      .nonneg (alu_nonneg)
   );

   assign rd = rd_data;

   always_comb begin
      init_rec      = '0;
      init_rec.size = SW'(HEAP_BYTES - HDR);
      init_rec.free = 1'b1;
      init_rec.live = 1'b1;
   end

   assign round_sum = {1'b0, req.new_size} + fla_pkg::REQ_W'(7);

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      clr_in   = clr_ff;
      hd_ok_in = hd_ok_ff;
      hd_in    = hd_ff;
      x_in     = x_ff;
      i_in     = i_ff;
      cur_in   = cur_ff;
      nx_in    = nx_ff;
      rr_in    = rr_ff;
      fprev_in = fprev_ff;
      fhp_in   = fhp_ff;
      found_in = found_ff;
      bsize_in = bsize_ff;
      req_in   = req_ff;
      m1_in    = m1_ff;
      in_in    = in_ff;
      res_in   = res_ff;
      t_in     = t_ff;
      n_in     = n_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_rec   = '0;
      rd_addr  = '0;
      alu_a    = '0;
      alu_b    = '0;
      alu_c    = '0;
      alu_d    = '0;
      status.idle = (state_ff == S_IDLE);
      status.done = (state_ff == S_DONE);

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_rec  = (clr_ff == '0) ? init_rec : '0;
            clr_in  = clr_ff + IW'(1);
            if (clr_ff == IW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               in_in    = req;
               req_in   = {round_sum[fla_pkg::REQ_W-1:3], 3'b000};
               m1_in    = (req.old_size < req.new_size) ? req.old_size : req.new_size;
               res_in   = '0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            alu_a = AW'(in_ff.payload_offset);
            alu_c = NEG_HDR;
            if (!in_ff.has_pointer) begin
               if (in_ff.new_size == '0) begin
                  state_in = S_DONE;
               end else begin
                  ret_in   = S_NEW_GOT;
                  state_in = S_SRC0;
               end
            end else if (alu_nonneg && in_ff.payload_offset[2:0] == 3'b000 &&
                         alu_res < AW'(HEAP_BYTES)) begin
               i_in     = alu_res[IW+2:3];
               rd_addr  = alu_res[IW+2:3];
               state_in = S_CHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CHK: begin
            alu_a    = AW'(rd.size);
            alu_d    = AW'(req_ff);
            bsize_in = rd.size;
            if (!(rd.live && !rd.free)) begin
               state_in = S_DONE;
            end else if (in_ff.new_size == '0) begin
               state_in = S_FREE0;
            end else if (alu_nonneg) begin
               res_in.result_present = 1'b1;
               res_in.result_offset  = in_ff.payload_offset;
               x_in     = i_ff;
               ret_in   = S_DONE;
               state_in = S_SPL0;
            end else if (rd.hn) begin
               nx_in    = rd.next;
               rd_addr  = rd.next;
               state_in = S_GROWCHK;
            end else begin
               ret_in   = S_MOVE_GOT;
               state_in = S_SRC0;
            end
         end
         S_GROWCHK: begin
            alu_a = AW'(bsize_ff);
            alu_b = AW'(rd.size);
            alu_c = AW'(HDR);
            alu_d = AW'(req_ff);
            if (rd.free && alu_nonneg) begin
               x_in     = nx_ff;
               ret_in   = S_GROW_ABS;
               state_in = S_UNL0;
            end else begin
               ret_in   = S_MOVE_GOT;
               state_in = S_SRC0;
            end
         end
         S_GROW_ABS: begin
            x_in     = i_ff;
            ret_in   = S_GROW_SPL;
            state_in = S_ABS0;
         end
         S_GROW_SPL: begin
            res_in.result_present = 1'b1;
            res_in.result_offset  = in_ff.payload_offset;
            x_in     = i_ff;
            ret_in   = S_DONE;
            state_in = S_SPL0;
         end
         S_NEW_GOT: begin
            if (found_ff) begin
               x_in     = cur_ff;
               ret_in   = S_NEW_SPL;
               state_in = S_UNL0;
            end else begin
               res_in.out_of_memory = 1'b1;
               state_in = S_DONE;
            end
         end
         S_NEW_SPL: begin
            alu_a = AW'({cur_ff, 3'b000});
            alu_c = AW'(HDR);
            res_in.result_present = 1'b1;
            res_in.result_offset  = alu_res[fla_pkg::OFF_W-1:0];
            x_in     = cur_ff;
            ret_in   = S_DONE;
            state_in = S_SPL0;
         end
         S_MOVE_GOT: begin
            if (found_ff) begin
               x_in     = cur_ff;
               ret_in   = S_MOVE_LEN;
               state_in = S_UNL0;
            end else begin
               res_in.out_of_memory = 1'b1;
               state_in = S_DONE;
            end
         end
         S_MOVE_LEN: begin
            alu_a = AW'(m1_ff);
            alu_d = AW'(bsize_ff);
            res_in.copy_needed = 1'b1;
            res_in.copy_source = in_ff.payload_offset;
            res_in.copy_length = alu_nonneg ? fla_pkg::SIZE_W'(bsize_ff) : m1_ff;
            state_in = S_MOVE_SPL;
         end
         S_MOVE_SPL: begin
            alu_a = AW'({cur_ff, 3'b000});
            alu_c = AW'(HDR);
            res_in.result_present = 1'b1;
            res_in.result_offset  = alu_res[fla_pkg::OFF_W-1:0];
            x_in     = cur_ff;
            ret_in   = S_FREE0;
            state_in = S_SPL0;
         end
         S_DONE: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         S_FREE0: begin
            rd_addr  = i_ff;
            state_in = S_FREE1;
         end
         S_FREE1: begin
            wr_en       = 1'b1;
            wr_addr     = i_ff;
            wr_rec      = rd;
            wr_rec.free = 1'b1;
            fhp_in      = rd.hp;
            fprev_in    = rd.prev;
            if (rd.hn) begin
               nx_in    = rd.next;
               rd_addr  = rd.next;
               state_in = S_FREE2;
            end else begin
               state_in = S_FREE3;
            end
         end
         S_FREE2: begin
            if (rd.free) begin
               x_in     = nx_ff;
               ret_in   = S_FREE_ABS;
               state_in = S_UNL0;
            end else begin
               state_in = S_FREE3;
            end
         end
         S_FREE_ABS: begin
            x_in     = i_ff;
            ret_in   = S_FREE3;
            state_in = S_ABS0;
         end
         S_FREE3: begin
            if (fhp_ff) begin
               rd_addr  = fprev_ff;
               state_in = S_FREE4;
            end else begin
               x_in     = i_ff;
               ret_in   = S_DONE;
               state_in = S_INS0;
            end
         end
         S_FREE4: begin
            if (rd.free) begin
               x_in     = fprev_ff;
               ret_in   = S_FREE_PABS;
               state_in = S_UNL0;
            end else begin
               x_in     = i_ff;
               ret_in   = S_DONE;
               state_in = S_INS0;
            end
         end
         S_FREE_PABS: begin
            x_in     = fprev_ff;
            ret_in   = S_FREE_PINS;
            state_in = S_ABS0;
         end
         S_FREE_PINS: begin
            x_in     = fprev_ff;
            ret_in   = S_DONE;
            state_in = S_INS0;
         end
         S_UNL0: begin
            rd_addr  = x_ff;
            state_in = S_UNL1;
         end
         S_UNL1: begin
            t_in        = rd;
            wr_en       = 1'b1;
            wr_addr     = x_ff;
            wr_rec      = rd;
            wr_rec.free = 1'b0;
            wr_rec.hpf  = 1'b0;
            wr_rec.hnf  = 1'b0;
            wr_rec.pf   = '0;
            wr_rec.nf   = '0;
            if (!rd.hpf) begin
               hd_ok_in = rd.hnf;
               hd_in    = rd.nf;
            end
            if (rd.hpf) begin
               rd_addr  = rd.pf;
               state_in = S_UNL2;
            end else if (rd.hnf) begin
               rd_addr  = rd.nf;
               state_in = S_UNL3;
            end else begin
               state_in = ret_ff;
            end
         end
         S_UNL2: begin
            wr_en      = 1'b1;
            wr_addr    = t_ff.pf;
            wr_rec     = rd;
            wr_rec.hnf = t_ff.hnf;
            wr_rec.nf  = t_ff.nf;
            if (t_ff.hnf) begin
               rd_addr  = t_ff.nf;
               state_in = S_UNL3;
            end else begin
               state_in = ret_ff;
            end
         end
         S_UNL3: begin
            wr_en      = 1'b1;
            wr_addr    = t_ff.nf;
            wr_rec     = rd;
            wr_rec.hpf = t_ff.hpf;
            wr_rec.pf  = t_ff.pf;
            state_in   = ret_ff;
         end
         S_INS0: begin
            rd_addr  = x_ff;
            state_in = S_INS1;
         end
         S_INS1: begin
            wr_en       = 1'b1;
            wr_addr     = x_ff;
            wr_rec      = rd;
            wr_rec.free = 1'b1;
            wr_rec.hpf  = 1'b0;
            wr_rec.pf   = '0;
            wr_rec.hnf  = hd_ok_ff;
            wr_rec.nf   = hd_ok_ff ? hd_ff : '0;
            if (hd_ok_ff) begin
               rd_addr  = hd_ff;
               state_in = S_INS2;
            end else begin
               hd_ok_in = 1'b1;
               hd_in    = x_ff;
               state_in = ret_ff;
            end
         end
         S_INS2: begin
            wr_en      = 1'b1;
            wr_addr    = hd_ff;
            wr_rec     = rd;
            wr_rec.hpf = 1'b1;
            wr_rec.pf  = x_ff;
            hd_ok_in   = 1'b1;
            hd_in      = x_ff;
            state_in   = ret_ff;
         end
         S_ABS0: begin
            rd_addr  = x_ff;
            state_in = S_ABS1;
         end
         S_ABS1: begin
            t_in     = rd;
            rd_addr  = rd.next;
            state_in = S_ABS2;
         end
         S_ABS2: begin
            n_in        = rd;
            alu_a       = AW'(t_ff.size);
            alu_b       = AW'(rd.size);
            alu_c       = AW'(HDR);
            wr_en       = 1'b1;
            wr_addr     = x_ff;
            wr_rec      = t_ff;
            wr_rec.size = alu_res[SW-1:0];
            wr_rec.hn   = rd.hn;
            wr_rec.next = rd.next;
            state_in    = S_ABS3;
         end
         S_ABS3: begin
            wr_en       = 1'b1;
            wr_addr     = t_ff.next;
            wr_rec      = n_ff;
            wr_rec.live = 1'b0;
            wr_rec.free = 1'b0;
            if (n_ff.hn) begin
               rd_addr  = n_ff.next;
               state_in = S_ABS4;
            end else begin
               state_in = ret_ff;
            end
         end
         S_ABS4: begin
            wr_en       = 1'b1;
            wr_addr     = n_ff.next;
            wr_rec      = rd;
            wr_rec.hp   = 1'b1;
            wr_rec.prev = x_ff;
            state_in    = ret_ff;
         end
         S_SPL0: begin
            rd_addr  = x_ff;
            state_in = S_SPL1;
         end
         S_SPL1: begin
            t_in  = rd;
            alu_a = AW'(rd.size);
            alu_c = NEG_HDR8;
            alu_d = AW'(req_ff);
            if (alu_nonneg) begin
               state_in = S_SPL2;
            end else begin
               state_in = ret_ff;
            end
         end
         S_SPL2: begin
            alu_a    = AW'(x_ff);
            alu_b    = AW'(req_ff[fla_pkg::REQ_W-1:3]);
            alu_c    = AW'(HDR / 8);
            rr_in    = alu_res[IW-1:0];
            state_in = S_SPL3;
         end
         S_SPL3: begin
            alu_a       = AW'(t_ff.size);
            alu_c       = NEG_HDR;
            alu_d       = AW'(req_ff);
            wr_en       = 1'b1;
            wr_addr     = rr_ff;
            wr_rec      = '0;
            wr_rec.size = alu_res[SW-1:0];
            wr_rec.live = 1'b1;
            wr_rec.hp   = 1'b1;
            wr_rec.prev = x_ff;
            wr_rec.hn   = t_ff.hn;
            wr_rec.next = t_ff.next;
            state_in    = S_SPL4;
         end
         S_SPL4: begin
            wr_en       = 1'b1;
            wr_addr     = x_ff;
            wr_rec      = t_ff;
            wr_rec.hn   = 1'b1;
            wr_rec.next = rr_ff;
            wr_rec.size = SW'(req_ff);
            if (t_ff.hn) begin
               rd_addr  = t_ff.next;
               state_in = S_SPL5;
            end else begin
               x_in     = rr_ff;
               state_in = S_INS0;
            end
         end
         S_SPL5: begin
            wr_en       = 1'b1;
            wr_addr     = t_ff.next;
            wr_rec      = rd;
            wr_rec.hp   = 1'b1;
            wr_rec.prev = rr_ff;
            x_in        = rr_ff;
            state_in    = S_INS0;
         end
         S_SRC0: begin
            if (hd_ok_ff) begin
               cur_in   = hd_ff;
               rd_addr  = hd_ff;
               state_in = S_SRC1;
            end else begin
               found_in = 1'b0;
               state_in = ret_ff;
            end
         end
         S_SRC1: begin
            alu_a = AW'(rd.size);
            alu_d = AW'(req_ff);
            if (alu_nonneg) begin
               found_in = 1'b1;
               state_in = ret_ff;
            end else if (rd.hnf) begin
               cur_in   = rd.nf;
               rd_addr  = rd.nf;
               state_in = S_SRC1;
            end else begin
               found_in = 1'b0;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ret_ff   <= S_DONE;
         clr_ff   <= '0;
         hd_ok_ff <= 1'b1;
         hd_ff    <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         clr_ff   <= clr_in;
         hd_ok_ff <= hd_ok_in;
         hd_ff    <= hd_in;
         found_ff <= found_in;
      end
      x_ff     <= x_in;
      i_ff     <= i_in;
      cur_ff   <= cur_in;
      nx_ff    <= nx_in;
      rr_ff    <= rr_in;
      fprev_ff <= fprev_in;
      fhp_ff   <= fhp_in;
      bsize_ff <= bsize_in;
      req_ff   <= req_in;
      m1_ff    <= m1_in;
      in_ff    <= in_in;
      res_ff   <= res_in;
      t_ff     <= t_in;
      n_ff     <= n_in;
   end

   assign rsp = res_ff;

endmodule

/* hdl/free_list_heap_allocator.sv */
// free_list_heap_allocator: top level, request intake and result register
// depends on fla_pkg, fla_core
//
//   channel  direction  handshake               payload
//   req_     in         req_valid / req_stall   has_pointer, payload_offset, old_size, new_size
//   rsp_     out        rsp_valid / rsp_stall   result fields, one item per request
//
// an item walks the free list first fit and merges neighbouring blocks; every
// step is a read or read-modify-write of the slot ram (one read and one write
// port), so the list walk and merges set how long an item takes.
// after reset a clearing pass writes all (HEAP_BYTES+7)/8 slots, with req_stall
// high throughout.
// a finished item waits in the output register while the next item is taken;
// the sequencer holds its next result until that register frees up.

module free_list_heap_allocator #(
   parameter int HEAP_BYTES   = 65536,
   parameter int HEADER_BYTES = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_has_pointer,
   input  logic [fla_pkg::OFF_W-1:0]    req_payload_offset,
   input  logic [fla_pkg::SIZE_W-1:0]   req_old_size,
   input  logic [fla_pkg::SIZE_W-1:0]   req_new_size,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_result_present,
   output logic [fla_pkg::OFF_W-1:0]    rsp_result_offset,
   output logic                         rsp_out_of_memory,
   output logic                         rsp_copy_needed,
   output logic [fla_pkg::OFF_W-1:0]    rsp_copy_source,
   output logic [fla_pkg::SIZE_W-1:0]   rsp_copy_length
);

   fla_pkg::req_type    req;
   fla_pkg::rsp_type    core_rsp;
   fla_pkg::rsp_type    out_ff, out_in;
   fla_pkg::status_type status;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_ready;
   logic                accept;

   assign req.has_pointer    = req_has_pointer;
   assign req.payload_offset = req_payload_offset;
   assign req.old_size       = req_old_size;
   assign req.new_size       = req_new_size;

   assign req_stall = ~status.idle;
   assign accept    = req_valid & status.idle;
   assign out_ready = ~rsp_valid_ff | ~rsp_stall;

   fla_core #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .req       (req),
      .out_ready (out_ready),
      .status    (status),
      .rsp       (core_rsp)
   );

   always_comb begin
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      if (status.done && out_ready) begin
         out_in       = core_rsp;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_present = out_ff.result_present;
   assign rsp_result_offset  = out_ff.result_offset;
   assign rsp_out_of_memory  = out_ff.out_of_memory;
   assign rsp_copy_needed    = out_ff.copy_needed;
   assign rsp_copy_source    = out_ff.copy_source;
   assign rsp_copy_length    = out_ff.copy_length;

endmodule

/* hdl/fla_checker.sv */
// fla_checker: port-level assertions for free_list_heap_allocator, with bind
// depends on fla_pkg and the top level's ports

module fla_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_result_present,
   input logic [fla_pkg::OFF_W-1:0]  rsp_result_offset,
   input logic                       rsp_out_of_memory,
   input logic                       rsp_copy_needed,
   input logic [fla_pkg::OFF_W-1:0]  rsp_copy_source,
   input logic [fla_pkg::SIZE_W-1:0] rsp_copy_length
);

   // clearing pass keeps the input stalled right after reset
   a_clear_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input taken during clearing pass");

   a_oom_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_memory |-> !rsp_result_present && !rsp_copy_needed)
      else $error("out_of_memory with a result");

   a_copy_moves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_copy_needed |-> rsp_result_present &&
         rsp_copy_source != rsp_result_offset)
      else $error("copy without a moved result");

   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_copy_needed |-> rsp_copy_source == '0 && rsp_copy_length == '0 &&
         (rsp_result_present || rsp_result_offset == '0))
      else $error("fields not cleared");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_offset))
      else $error("stalled item changed");

endmodule

bind free_list_heap_allocator fla_checker u_fla_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result_present (rsp_result_present),
   .rsp_result_offset  (rsp_result_offset),
   .rsp_out_of_memory  (rsp_out_of_memory),
   .rsp_copy_needed    (rsp_copy_needed),
   .rsp_copy_source    (rsp_copy_source),
   .rsp_copy_length    (rsp_copy_length)
);

/* bench/tb_free_list_heap_allocator.sv */
// tb_free_list_heap_allocator: self-checking bench for the free-list heap allocator
// predicts every result with a slot-level model of the heap and compares field by field
// depends on fla_pkg and free_list_heap_allocator

module tb_free_list_heap_allocator;

   localparam int HEAP   = 65536;
   localparam int HDRB   = 48;
   localparam int HDR    = (HDRB + 7) & ~7;
   localparam int NSLOT  = (HEAP + 7) / 8;
   localparam int WDOG   = 40000;

   typedef struct {
      int unsigned sz;
      bit          fr, lv;
      bit          hp, hn, hpf, hnf;
      int unsigned prv, nxt, pf, nf;
   } slot_t;

   logic                       clock, reset;
   logic                       req_valid, req_stall;
   logic                       req_has_pointer;
   logic [fla_pkg::OFF_W-1:0]  req_payload_offset;
   logic [fla_pkg::SIZE_W-1:0] req_old_size, req_new_size;
   logic                       rsp_valid, rsp_stall;
   logic                       rsp_result_present, rsp_out_of_memory, rsp_copy_needed;
   logic [fla_pkg::OFF_W-1:0]  rsp_result_offset, rsp_copy_source;
   logic [fla_pkg::SIZE_W-1:0] rsp_copy_length;

   slot_t            heap_map [NSLOT];
   bit               head_ok;
   int unsigned      head_idx;
   fla_pkg::rsp_type expected_q [$];
   int unsigned      live_offs [$];
   int unsigned      live_sizes [$];
   int               errors, n_sent, n_got, idle_cycles;
   bit               hold_off;

   free_list_heap_allocator dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic void unlink_free(int unsigned i);
      if (heap_map[i].hpf) begin
         heap_map[heap_map[i].pf].hnf = heap_map[i].hnf;
         heap_map[heap_map[i].pf].nf  = heap_map[i].nf;
      end else begin
         head_ok  = heap_map[i].hnf;
         head_idx = heap_map[i].nf;
      end
      if (heap_map[i].hnf) begin
         heap_map[heap_map[i].nf].hpf = heap_map[i].hpf;
         heap_map[heap_map[i].nf].pf  = heap_map[i].pf;
      end
      heap_map[i].hpf = 0; heap_map[i].hnf = 0; heap_map[i].pf = 0; heap_map[i].nf = 0;
   endfunction

   function automatic void insert_free(int unsigned i);
      heap_map[i].fr  = 1;
      heap_map[i].hpf = 0; heap_map[i].pf = 0;
      heap_map[i].hnf = head_ok; heap_map[i].nf = head_ok ? head_idx : 0;
      if (head_ok) begin
         heap_map[head_idx].hpf = 1; heap_map[head_idx].pf = i;
      end
      head_ok = 1; head_idx = i;
   endfunction

   function automatic void split_at(int unsigned i, int unsigned rq);
      int unsigned r;
      if (heap_map[i].sz < rq + HDR + 8) return;
      r = i + (HDR + rq) / 8;
      heap_map[r].sz = heap_map[i].sz - rq - HDR;
      heap_map[r].lv = 1;
      heap_map[r].hp = 1; heap_map[r].prv = i;
      heap_map[r].hn = heap_map[i].hn; heap_map[r].nxt = heap_map[i].nxt;
      if (heap_map[i].hn) begin
         heap_map[heap_map[i].nxt].hp = 1; heap_map[heap_map[i].nxt].prv = r;
      end
      heap_map[i].hn = 1; heap_map[i].nxt = r;
      heap_map[i].sz = rq;
      insert_free(r);
   endfunction

   function automatic void merge_next(int unsigned i);
      int unsigned n;
      n = heap_map[i].nxt;
      heap_map[i].sz += HDR + heap_map[n].sz;
      heap_map[i].hn = heap_map[n].hn; heap_map[i].nxt = heap_map[n].nxt;
      heap_map[n].lv = 0; heap_map[n].fr = 0;
      if (heap_map[i].hn) begin
         heap_map[heap_map[i].nxt].hp = 1; heap_map[heap_map[i].nxt].prv = i;
      end
   endfunction

   function automatic void release_block(int unsigned i);
      int unsigned p;
      heap_map[i].fr = 1;
      if (heap_map[i].hn && heap_map[heap_map[i].nxt].fr) begin
         unlink_free(heap_map[i].nxt); merge_next(i);
      end
      if (heap_map[i].hp && heap_map[heap_map[i].prv].fr) begin
         p = heap_map[i].prv;
         unlink_free(p); merge_next(p); i = p;
      end
      insert_free(i);
   endfunction

   function automatic bit first_fit(int unsigned rq, output int unsigned at);
      bit ok;
      int unsigned cur;
      ok = head_ok; cur = head_idx; at = 0;
      for (int n = 0; ok && n < NSLOT; n++) begin
         if (heap_map[cur].sz >= rq) begin
            unlink_free(cur);
            heap_map[cur].fr = 0;
            split_at(cur, rq);
            at = cur;
            return 1;
         end
         ok = heap_map[cur].hnf; cur = heap_map[cur].nf;
      end
      return 0;
   endfunction

   function automatic void heap_reset();
      slot_t z;
      z = '{default: 0};
      foreach (heap_map[k]) heap_map[k] = z;
      heap_map[0].sz = HEAP - HDR; heap_map[0].fr = 1; heap_map[0].lv = 1;
      head_ok = 1; head_idx = 0;
   endfunction

   function automatic fla_pkg::rsp_type predict_alloc(bit hasp, int unsigned poff,
                                                       int unsigned olds, int unsigned news);
      fla_pkg::rsp_type r;
      int unsigned rq, at, i, len;
      r = '0;
      rq = (news + 7) & ~32'd7;
      if (!hasp) begin
         if (news != 0) begin
            if (first_fit(rq, at)) begin
               r.result_present = 1; r.result_offset = fla_pkg::OFF_W'(at * 8 + HDR);
            end else r.out_of_memory = 1;
         end
      end else if (poff >= HDR && ((poff - HDR) & 7) == 0 && (poff - HDR) < HEAP) begin
         i = (poff - HDR) / 8;
         if (heap_map[i].lv && !heap_map[i].fr) begin
            if (news == 0) release_block(i);
            else if (rq <= heap_map[i].sz) begin
               split_at(i, rq);
               r.result_present = 1; r.result_offset = fla_pkg::OFF_W'(poff);
            end else if (heap_map[i].hn && heap_map[heap_map[i].nxt].fr &&
                         heap_map[i].sz + HDR + heap_map[heap_map[i].nxt].sz >= rq) begin
               unlink_free(heap_map[i].nxt); merge_next(i); split_at(i, rq);
               r.result_present = 1; r.result_offset = fla_pkg::OFF_W'(poff);
            end else if (first_fit(rq, at)) begin
               len = olds < news ? olds : news;
               if (len > heap_map[i].sz) len = heap_map[i].sz;
               r.result_present = 1; r.result_offset = fla_pkg::OFF_W'(at * 8 + HDR);
               r.copy_needed = 1; r.copy_source = fla_pkg::OFF_W'(poff);
               r.copy_length = fla_pkg::SIZE_W'(len);
               release_block(i);
            end else r.out_of_memory = 1;
         end
      end
      return r;
   endfunction

   // keep a list of live payloads so that most requests hit real blocks
   function automatic void track(bit hasp, int unsigned poff, int unsigned news,
                                 fla_pkg::rsp_type r);
      int idx;
      idx = -1;
      if (hasp) foreach (live_offs[k]) if (live_offs[k] == poff) idx = k;
      if (r.out_of_memory) return;
      if (idx >= 0 && (news == 0 || r.result_present)) begin
         live_offs.delete(idx); live_sizes.delete(idx);
      end
      if (r.result_present) begin
         live_offs.push_back(r.result_offset); live_sizes.push_back(news);
      end
   endfunction

   task automatic send_item(bit hasp, int unsigned poff, int unsigned olds, int unsigned news);
      fla_pkg::rsp_type r;
      poff = poff & 32'hFFFF;
      olds = olds & 32'h1FFFF;
      news = news & 32'h1FFFF;
      repeat ($urandom_range(0, 12) * (($urandom_range(0, 3) == 0) ? 0 : 1)) @(negedge clock);
      req_has_pointer = hasp; req_payload_offset = fla_pkg::OFF_W'(poff);
      req_old_size = fla_pkg::SIZE_W'(olds); req_new_size = fla_pkg::SIZE_W'(news);
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      r = predict_alloc(hasp, poff, olds, news);
      expected_q.push_back(r);
      track(hasp, poff, news, r);
      n_sent++;
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic send_live(int unsigned news);
      int k;
      if (live_offs.size() == 0) begin
         send_item(0, 0, 0, news);
         return;
      end
      k = $urandom_range(0, live_offs.size() - 1);
      send_item(1, live_offs[k], live_sizes[k] + $urandom_range(0, 16), news);
   endtask

   task automatic wait_drain();
      while (expected_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic test_directed();
      send_item(0, 0, 0, 0);
      send_item(0, 0, 0, 1);
      send_item(0, 0, 0, 8);
      send_item(0, 0, 0, 100);
      send_item(0, 0, 0, 131071);
      send_item(0, 0, 0, 65536);
      send_item(1, 0, 0, 0);
      send_item(1, 65535, 131071, 5);
      send_item(1, HDR + 4, 0, 8);
      send_item(1, 56, 1, 8);
      send_live(4);
      send_live(3000);
      send_live(0);
      send_live(0);
      send_item(0, 0, 0, 200);
      send_item(0, 0, 0, 40);
      send_live(0);
      send_item(0, 0, 0, HEAP - 4 * HDR);
      send_item(0, 0, 0, 16);
      send_live(20000);
      while (live_offs.size() != 0) send_live(0);
      send_item(0, 0, 0, HEAP - HDR);
      send_live(0);
      wait_drain();
   endtask

   task automatic test_random();
      int unsigned v;
      for (int n = 0; n < 760; n++) begin
         v = $urandom_range(0, 99);
         if (v < 35 || live_offs.size() == 0)
            send_item(0, 0, 0, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 131071)
                                                           : $urandom_range(1, 600));
         else if (v < 65) send_live(0);
         else if (v < 88) send_live(($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
                                                               : $urandom_range(1, 1200));
         else send_item(1, $urandom(), $urandom_range(0, 131071), $urandom_range(0, 131071));
      end
      wait_drain();
   endtask

   task automatic test_backpressure();
      hold_off = 1;
      for (int n = 0; n < 20; n++) send_item(0, 0, 0, $urandom_range(1, 64));
      while (live_offs.size() != 0) send_live(0);
      wait_drain();
   endtask

   // result side: random stalls plus one long hold-off
   initial begin
      int gap, held;
      rsp_stall = 1;
      gap = 0; held = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off && held < 300) begin
            rsp_stall = 1; held++;
            if (held == 300) hold_off = 0;
         end else if (gap > 0) begin
            rsp_stall = 1; gap--;
         end else begin
            rsp_stall = 0;
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(0, 12);
         end
      end
   end

   always @(posedge clock) begin
      fla_pkg::rsp_type e;
      if (!reset && (req_valid && !req_stall || rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_got++;
         if (expected_q.size() == 0) begin
            $display("%0t unexpected item: present %0b offset %0d oom %0b", $time,
                     rsp_result_present, rsp_result_offset, rsp_out_of_memory);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if ({rsp_result_present, rsp_result_offset, rsp_out_of_memory, rsp_copy_needed,
                 rsp_copy_source, rsp_copy_length} !== e) begin
               $display("%0t mismatch expected present %0b off %0d oom %0b cp %0b src %0d len %0d",
                        $time, e.result_present, e.result_offset, e.out_of_memory,
                        e.copy_needed, e.copy_source, e.copy_length);
               $display("%0t          actual   present %0b off %0d oom %0b cp %0b src %0d len %0d",
                        $time, rsp_result_present, rsp_result_offset, rsp_out_of_memory,
                        rsp_copy_needed, rsp_copy_source, rsp_copy_length);
               errors++;
            end
         end
      end
      if (idle_cycles > WDOG) begin
         $display("watchdog: %0d cycles without progress", idle_cycles);
         $display("[free_list_heap_allocator] ERROR");
         $finish;
      end
   end

   initial begin
      errors = 0; n_sent = 0; n_got = 0; idle_cycles = 0; hold_off = 0;
      reset = 1; req_valid = 0; req_has_pointer = 0; req_payload_offset = 0;
      req_old_size = 0; req_new_size = 0;
      heap_reset();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_random();
      test_backpressure();
      if (expected_q.size() != 0) errors++;
      $display("covered %0d requests and %0d results: allocs, frees, shrinks, grows, moves,",
               n_sent, n_got);
      $display("bad pointers, out-of-memory and a long result-side hold-off");
      if (errors == 0) $display("[free_list_heap_allocator] OK");
      else $display("[free_list_heap_allocator] ERROR");
      $finish;
   end

endmodule
